[design/isrl_pkg.sv]
package isrl_pkg;

  // Store geometry.
  localparam int USERS = 64;
  localparam int ITEMS = 64;
  localparam int J_W   = $clog2(ITEMS);
  localparam int RA_W  = $clog2(USERS * ITEMS);
  localparam int WA_W  = $clog2(ITEMS * ITEMS);
  localparam int CLR_N = (USERS * ITEMS > ITEMS * ITEMS) ? USERS * ITEMS : ITEMS * ITEMS;
  localparam int CLR_W = $clog2(CLR_N);

  // Accumulator and divider widths.
  localparam int S_W   = 32 + J_W;
  localparam int P_W   = S_W + 3;
  localparam int DVD_W = (P_W + 8 > 35) ? P_W + 8 : 35;
  localparam int DVS_W = S_W;
  localparam int CNT_W = $clog2(DVD_W);
  localparam int G_W   = 36;

  // Rating scale constants in Q3.8.
  localparam logic [10:0] ONE_Q8     = 11'd256;
  localparam logic [10:0] FIVE_Q8    = 11'd1280;
  localparam logic [2:0]  MAX_RATING = 3'd5;

  // Configuration registers.
  localparam logic        REG_LEARN_RATE = 1'b0;
  localparam logic        REG_DECAY      = 1'b1;
  localparam logic [15:0] LEARN_RATE_RST = 16'd852;
  localparam logic [15:0] DECAY_RST      = 16'd66;

  typedef enum logic [1:0] {
    MODE_LOAD_RATING = 2'd0,
    MODE_LOAD_WEIGHT = 2'd1,
    MODE_PREDICT     = 2'd2,
    MODE_TRAIN       = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM_ADDR,
    ST_SUM_ACC,
    ST_CHECK,
    ST_PRED_GO,
    ST_PRED_WAIT,
    ST_ERR,
    ST_GRAD_GO,
    ST_GRAD_WAIT,
    ST_UPD_ADDR,
    ST_UPD_MUL,
    ST_UPD_INNER,
    ST_UPD_SCALE,
    ST_UPD_WRITE,
    ST_RESULT
  } st_e;

endpackage

[design/item_similarity_rating_learner_top.sv]
// Item-item similarity rating learner.
// Input stream: s_axis_tuser carries the mode (load rating, load weight,
// predict, train); s_axis_tdata carries user, item, other item, rating and
// weight. Every request gives exactly one result on the output stream:
// prediction and error in m_axis_tdata, the zero weight sum flag in
// m_axis_tuser. Learning rate and decay are written on the cfg channel,
// which is always ready.
// After reset the block clears both stores, one entry per cycle, and
// s_axis_tready stays low during that pass.
// Predict walks the user's rating row one item at a time, then runs one
// bit-serial division. Train adds a second division and a walk over the
// weight row. The divider is shared by both divisions, and each store has
// a single write port. One request is worked on at a time.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is already accepted and computed, and that
// request's result waits until the register is free.
module item_similarity_rating_learner_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // user_index[5:0], item_index[11:6], other_item[17:12], rating_value[20:18],
  // weight_value[52:21], zero fill above.
  input  logic [55:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // prediction[10:0], error[22:11], zero fill above.
  output logic [23:0] m_axis_tdata,
  // no_weight[0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import isrl_pkg::*;

  // Input fields.
  logic [5:0]         in_user, in_item, in_other;
  logic [2:0]         in_rating, in_rating_clip;
  logic [31:0]        in_weight;
  mode_e              in_mode;

  assign in_user        = s_axis_tdata[5:0];
  assign in_item        = s_axis_tdata[11:6];
  assign in_other       = s_axis_tdata[17:12];
  assign in_rating      = s_axis_tdata[20:18];
  assign in_weight      = s_axis_tdata[52:21];
  assign in_mode        = mode_e'(s_axis_tuser);
  assign in_rating_clip = (in_rating > MAX_RATING) ? MAX_RATING : in_rating;

  // Registers.
  st_e                state_q, state_d;
  logic [CLR_W-1:0]   clr_q;
  logic [15:0]        lr_q, decay_q;
  mode_e              mode_q;
  logic [5:0]         u_q, t_q;
  logic [2:0]         r_q;
  logic               ok_q;
  logic [J_W-1:0]     j_q;
  logic signed [S_W-1:0] s_q;
  logic signed [P_W-1:0] p_q;
  logic [10:0]        pred_q;
  logic signed [11:0] err_q;
  logic               nw_q;
  logic signed [G_W-1:0] g_q;
  logic signed [39:0] gr_q;
  logic signed [48:0] dw_q;
  logic signed [40:0] inner_q;
  logic signed [57:0] li_q;
  logic signed [31:0] w_hold_q;
  logic               out_valid_q;
  logic [10:0]        out_pred_q;
  logic [11:0]        out_err_q;
  logic               out_nw_q;

  // Stores.
  logic [2:0]         rating_mem [USERS*ITEMS];
  logic [31:0]        weight_mem [ITEMS*ITEMS];
  logic [2:0]         rd_r_q;
  logic signed [31:0] rd_w_q;
  logic [RA_W-1:0]    ra_rd, ra_wr;
  logic [WA_W-1:0]    wa_rd, wa_wr;
  logic               r_we, w_we;
  logic [2:0]         r_wdata;
  logic [31:0]        w_wdata;

  // Control strobes.
  logic               accept, last_j, out_free, div_start, div_done;
  logic [DVD_W-1:0]   div_dvd, div_quo;
  logic [DVS_W-1:0]   s_mag;
  logic               s_neg, p_neg, e_neg;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign last_j   = (j_q == J_W'(ITEMS - 1));
  assign out_free = !out_valid_q || m_axis_tready;

  // Read addresses of the current walk.
  assign ra_rd = RA_W'(RA_W'(u_q) * RA_W'(ITEMS) + RA_W'(j_q));
  assign wa_rd = WA_W'(WA_W'(t_q) * WA_W'(ITEMS) + WA_W'(j_q));

  // Division operands: magnitudes and signs.
  logic signed [DVD_W-1:0] p_ext;
  logic [10:0]        err_mag;
  always_comb begin
    s_neg   = s_q[S_W-1];
    p_neg   = p_q[P_W-1];
    e_neg   = err_q[11];
    s_mag   = s_neg ? DVS_W'(-s_q) : DVS_W'(s_q);
    p_ext   = DVD_W'({p_q, 8'd0});
    err_mag = e_neg ? 11'(-err_q) : 11'(err_q);
    if (state_q == ST_GRAD_GO) begin
      div_dvd = DVD_W'({err_mag, 24'd0});
    end else begin
      div_dvd = p_neg ? DVD_W'(-p_ext) : DVD_W'(p_ext);
    end
  end

  isrl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (s_mag),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Clamped prediction from the quotient.
  logic [10:0] pred_clamp;
  always_comb begin
    if (p_neg ^ s_neg) begin
      pred_clamp = ONE_Q8;
    end else if (div_quo > DVD_W'(FIVE_Q8)) begin
      pred_clamp = FIVE_Q8;
    end else if (div_quo < DVD_W'(ONE_Q8)) begin
      pred_clamp = ONE_Q8;
    end else begin
      pred_clamp = div_quo[10:0];
    end
  end

  // Signed gradient from the quotient.
  logic signed [G_W-1:0] g_val;
  assign g_val = (e_neg ^ s_neg) ? -$signed(div_quo[G_W-1:0]) : $signed(div_quo[G_W-1:0]);

  // Update arithmetic.
  logic signed [32:0] dw_trunc;
  logic signed [41:0] delta;
  logic signed [42:0] w_sum;
  logic signed [31:0] w_sat;
  always_comb begin
    dw_trunc = dw_q[48] ? 33'((dw_q + 49'sd65535) >>> 16) : 33'(dw_q >>> 16);
    delta    = li_q[57] ? 42'((li_q + 58'sd65535) >>> 16) : 42'(li_q >>> 16);
    w_sum    = 43'(w_hold_q) + 43'(delta);
    if (w_sum > 43'sd2147483647) begin
      w_sat = 32'sh7FFFFFFF;
    end else if (w_sum < -43'sd2147483648) begin
      w_sat = 32'sh80000000;
    end else begin
      w_sat = 32'(w_sum);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:     if (clr_q == CLR_W'(CLR_N - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_LOAD_RATING || in_mode == MODE_LOAD_WEIGHT) begin
            state_d = ST_RESULT;
          end else if (32'(in_user) < 32'(USERS) && 32'(in_item) < 32'(ITEMS)) begin
            state_d = ST_SUM_ADDR;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_SUM_ADDR:  state_d = ST_SUM_ACC;
      ST_SUM_ACC:   state_d = last_j ? ST_CHECK : ST_SUM_ADDR;
      ST_CHECK:     state_d = (s_q == '0) ? ST_ERR : ST_PRED_GO;
      ST_PRED_GO:   state_d = ST_PRED_WAIT;
      ST_PRED_WAIT: if (div_done) state_d = ST_ERR;
      ST_ERR:       state_d = (mode_q == MODE_TRAIN && s_q != '0) ? ST_GRAD_GO : ST_RESULT;
      ST_GRAD_GO:   state_d = ST_GRAD_WAIT;
      ST_GRAD_WAIT: if (div_done) state_d = ST_UPD_ADDR;
      ST_UPD_ADDR:  state_d = ST_UPD_MUL;
      ST_UPD_MUL:   state_d = ST_UPD_INNER;
      ST_UPD_INNER: state_d = ST_UPD_SCALE;
      ST_UPD_SCALE: state_d = ST_UPD_WRITE;
      ST_UPD_WRITE: state_d = last_j ? ST_RESULT : ST_UPD_ADDR;
      ST_RESULT:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_CLEAR;
    endcase
  end

  // Control outputs and store write ports.
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    r_we          = 1'b0;
    w_we          = 1'b0;
    ra_wr         = ra_rd;
    wa_wr         = wa_rd;
    r_wdata       = 3'd0;
    w_wdata       = 32'd0;
    case (state_q)
      ST_CLEAR: begin
        r_we  = (32'(clr_q) < 32'(USERS * ITEMS));
        w_we  = (32'(clr_q) < 32'(ITEMS * ITEMS));
        ra_wr = RA_W'(clr_q);
        wa_wr = WA_W'(clr_q);
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ra_wr   = RA_W'(RA_W'(in_user) * RA_W'(ITEMS) + RA_W'(in_item));
        wa_wr   = WA_W'(WA_W'(in_item) * WA_W'(ITEMS) + WA_W'(in_other));
        r_wdata = in_rating_clip;
        w_wdata = in_weight;
        r_we    = s_axis_tvalid && in_mode == MODE_LOAD_RATING &&
                  32'(in_user) < 32'(USERS) && 32'(in_item) < 32'(ITEMS);
        w_we    = s_axis_tvalid && in_mode == MODE_LOAD_WEIGHT &&
                  32'(in_item) < 32'(ITEMS) && 32'(in_other) < 32'(ITEMS);
      end
      ST_PRED_GO, ST_GRAD_GO: div_start = 1'b1;
      ST_UPD_WRITE: begin
        w_we    = 1'b1;
        w_wdata = w_sat;
      end
      default: ;
    endcase
  end

  // Stores: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (r_we) rating_mem[ra_wr] <= r_wdata;
    if (w_we) weight_mem[wa_wr] <= w_wdata;
    rd_r_q <= rating_mem[ra_rd];
    rd_w_q <= $signed(weight_mem[wa_rd]);
  end

  // Sequencer control state, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      lr_q        <= LEARN_RATE_RST;
      decay_q     <= DECAY_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LEARN_RATE: lr_q    <= cfg_data_i;
          REG_DECAY:      decay_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mode_q <= in_mode;
        u_q    <= in_user;
        t_q    <= in_item;
        r_q    <= in_rating_clip;
        ok_q   <= 32'(in_user) < 32'(USERS) && 32'(in_item) < 32'(ITEMS);
        j_q    <= '0;
        s_q    <= '0;
        p_q    <= '0;
        pred_q <= 11'd0;
        err_q  <= 12'sd0;
        nw_q   <= 1'b0;
      end
      ST_SUM_ACC: begin
        if (rd_r_q != 3'd0) begin
          s_q <= s_q + S_W'(rd_w_q);
          p_q <= p_q + P_W'(rd_w_q) * P_W'($signed({1'b0, rd_r_q}));
        end
        j_q <= j_q + 1'b1;
      end
      ST_CHECK: begin
        if (s_q == '0) begin
          pred_q <= ONE_Q8;
          nw_q   <= 1'b1;
        end
      end
      ST_PRED_WAIT: if (div_done) pred_q <= pred_clamp;
      ST_ERR: begin
        if (mode_q == MODE_TRAIN) begin
          err_q <= $signed({1'b0, r_q, 8'd0}) - $signed({1'b0, pred_q});
        end
      end
      ST_GRAD_WAIT: begin
        if (div_done) begin
          g_q <= g_val;
          j_q <= '0;
        end
      end
      ST_UPD_MUL: begin
        gr_q     <= g_q * $signed({1'b0, rd_r_q});
        dw_q     <= $signed({1'b0, decay_q}) * rd_w_q;
        w_hold_q <= rd_w_q;
      end
      ST_UPD_INNER: inner_q <= 41'(gr_q) - 41'(dw_trunc);
      ST_UPD_SCALE: li_q <= $signed({1'b0, lr_q}) * inner_q;
      ST_UPD_WRITE: j_q <= j_q + 1'b1;
      ST_RESULT: begin
        if (out_free) begin
          out_pred_q <= pred_q;
          out_err_q  <= err_q;
          out_nw_q   <= nw_q;
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_err_q, out_pred_q};
  assign m_axis_tuser  = out_nw_q;

  // A zero weight sum always reports a prediction of one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[10:0] == ONE_Q8)
    else $error("no_weight result without unit prediction");

  // Predictions are either zero (loads) or within the rating scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:0] == 11'd0 ||
      (m_axis_tdata[10:0] >= ONE_Q8 && m_axis_tdata[10:0] <= FIVE_Q8))
    else $error("prediction outside rating scale");

  // The gradient division never starts on a zero weight sum or out of range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GRAD_GO |-> s_q != '0 && ok_q && mode_q == MODE_TRAIN)
    else $error("weight update started without a valid weight sum");

endmodule

[design/isrl_div.sv]
module isrl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [isrl_pkg::DVD_W-1:0] dividend_i,
  input  logic [isrl_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [isrl_pkg::DVD_W-1:0] quotient_o
);
  import isrl_pkg::*;

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, rem_d, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   shift, diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    shift = {rem_q, quo_q[DVD_W-1]};
    diff  = shift - {1'b0, dvs_q};
    ge    = (shift >= {1'b0, dvs_q});
    rem_d = ge ? diff[DVS_W-1:0] : shift[DVS_W-1:0];
  end

  // Control: count one quotient bit per cycle while busy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[tb/sv/item_similarity_rating_learner_top_tb.sv]
module item_similarity_rating_learner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import isrl_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [10:0] prediction;
    logic [11:0] error;
    logic        no_weight;
  } rating_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = MODE_LOAD_RATING;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = REG_LEARN_RATE;
  logic [15:0] cfg_data_i = '0;

  item_similarity_rating_learner_top DUT (.*);

  always #6 clk_i = ~clk_i;

  // Shadow copy of the learner state.
  logic [2:0]         shadow_ratings [USERS*ITEMS];
  logic signed [31:0] shadow_weights [ITEMS*ITEMS];
  logic [15:0]        shadow_learn_rate;
  logic [15:0]        shadow_decay;
  rating_result_t     expected_results [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  idle_cycles;
  bit  failed;

  function automatic longint trunc_div(longint n, longint d);
    longint q;
    if (d == 0) return 0;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic logic [2:0] limit_rating(logic [2:0] r);
    return (r > MAX_RATING) ? MAX_RATING : r;
  endfunction

  // Applies one request to the shadow state and returns its result.
  function automatic rating_result_t predict_and_learn(logic [1:0] mode, int u, int t, int o,
                                                       logic [2:0] rv, logic signed [31:0] wv);
    rating_result_t res;
    longint s, p, pred, err, g, w, inner, delta, nw;
    logic [2:0] r;
    r = limit_rating(rv);
    res = '0;
    s = 0;
    p = 0;
    if (mode == MODE_LOAD_RATING) begin
      shadow_ratings[u*ITEMS + t] = r;
      return res;
    end
    if (mode == MODE_LOAD_WEIGHT) begin
      shadow_weights[t*ITEMS + o] = wv;
      return res;
    end
    for (int j = 0; j < ITEMS; j++) begin
      if (shadow_ratings[u*ITEMS + j] != 0) begin
        s += shadow_weights[t*ITEMS + j];
        p += longint'(shadow_weights[t*ITEMS + j]) * shadow_ratings[u*ITEMS + j];
      end
    end
    if (s == 0) begin
      pred = 256;
      res.no_weight = 1'b1;
    end else begin
      pred = trunc_div(p * 256, s);
      if (pred < 256) pred = 256;
      if (pred > 1280) pred = 1280;
    end
    res.prediction = pred[10:0];
    if (mode == MODE_TRAIN) begin
      err = longint'(r) * 256 - pred;
      res.error = err[11:0];
      if (s != 0) begin
        g = trunc_div(err * 64'sd16777216, s);
        for (int j = 0; j < ITEMS; j++) begin
          w = shadow_weights[t*ITEMS + j];
          inner = g * shadow_ratings[u*ITEMS + j] - trunc_div(longint'(shadow_decay) * w, 65536);
          delta = trunc_div(longint'(shadow_learn_rate) * inner, 65536);
          nw = w + delta;
          if (nw > 64'sd2147483647) nw = 64'sd2147483647;
          if (nw < -64'sd2147483648) nw = -64'sd2147483648;
          shadow_weights[t*ITEMS + j] = nw[31:0];
        end
      end
    end
    return res;
  endfunction

  // Sends one request and records its expected result at acceptance.
  // Valid stays high after acceptance so requests can follow back to back.
  task automatic send_request(logic [1:0] mode, int u, int t, int o, logic [2:0] rv,
                              logic signed [31:0] wv);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {3'b0, wv, rv, o[5:0], t[5:0], u[5:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.insert(expected_results.size(),
                            predict_and_learn(mode, u, t, o, rv, wv));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [15:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_LEARN_RATE) shadow_learn_rate = value;
    else shadow_decay = value;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    rating_result_t got, exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[10:0], m_axis_tdata[22:11], m_axis_tuser};
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", got);
        failed = 1'b1;
      end else begin
        exp_res = expected_results.pop_front();
        if (got.prediction !== exp_res.prediction) begin
          $error("prediction expected %0d actual %0d", exp_res.prediction, got.prediction);
          failed = 1'b1;
        end
        if (got.error !== exp_res.error) begin
          $error("error expected %0d actual %0d", $signed(exp_res.error), $signed(got.error));
          failed = 1'b1;
        end
        if (got.no_weight !== exp_res.no_weight) begin
          $error("no_weight expected %0d actual %0d", exp_res.no_weight, got.no_weight);
          failed = 1'b1;
        end
      end
    end
  end

  // Receiver stalls.
  always @(posedge clk_i) begin
    m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("item_similarity_rating_learner_top_tb: FAIL");
      $finish;
    end
  end

  // Directed: extremes of fields, every mode, zero sum, out-of-range ratings.
  task automatic test_directed();
    send_request(MODE_PREDICT, 0, 0, 0, 3'd0, 32'sd0);
    send_request(MODE_TRAIN, 63, 63, 0, 3'd7, 32'sd0);
    send_request(MODE_LOAD_RATING, 0, 0, 0, 3'd7, 32'sd0);
    send_request(MODE_LOAD_RATING, 0, 1, 0, 3'd1, 32'sd0);
    send_request(MODE_LOAD_RATING, 0, 63, 0, 3'd6, 32'sd0);
    send_request(MODE_LOAD_WEIGHT, 0, 0, 0, 3'd0, 32'sh7FFF_FFFF);
    send_request(MODE_LOAD_WEIGHT, 0, 0, 1, 3'd0, -32'sh8000_0000);
    send_request(MODE_LOAD_WEIGHT, 0, 0, 63, 3'd0, 32'sh0001_0000);
    send_request(MODE_PREDICT, 0, 0, 0, 3'd0, 32'sd0);
    send_request(MODE_TRAIN, 0, 0, 0, 3'd5, 32'sd0);
    send_request(MODE_TRAIN, 0, 0, 0, 3'd1, 32'sd0);
    send_request(MODE_LOAD_WEIGHT, 0, 63, 1, 3'd0, 32'sh0000_8000);
    send_request(MODE_LOAD_WEIGHT, 0, 63, 63, 3'd0, -32'sh0000_8000);
    send_request(MODE_PREDICT, 0, 63, 0, 3'd0, 32'sd0);
    send_request(MODE_TRAIN, 0, 63, 0, 3'd3, 32'sd0);
    send_request(MODE_LOAD_RATING, 63, 63, 63, 3'd5, 32'sh5555_AAAA);
    send_request(MODE_TRAIN, 63, 0, 0, 3'd0, 32'sd0);
  endtask

  // Random: small neighborhoods so rows become densely rated and trained.
  task automatic test_random(int count);
    int u, t, o, pick;
    logic [1:0] mode;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 25) mode = MODE_LOAD_RATING;
      else if (pick < 50) mode = MODE_LOAD_WEIGHT;
      else if (pick < 70) mode = MODE_PREDICT;
      else mode = MODE_TRAIN;
      if ($urandom_range(9, 0) < 8) begin
        u = $urandom_range(3, 0);
        t = $urandom_range(7, 0);
        o = $urandom_range(7, 0);
      end else begin
        u = $urandom_range(63, 0);
        t = $urandom_range(63, 0);
        o = $urandom_range(63, 0);
      end
      send_request(mode, u, t, o, 3'($urandom_range(7, 0)),
                   ($urandom_range(3, 0) == 0) ? $urandom()
                                               : 32'($signed($urandom_range(262144, 0)) - 65536));
    end
  endtask

  initial begin
    failed = 1'b0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_learn_rate = LEARN_RATE_RST;
    shadow_decay = DECAY_RST;
    foreach (shadow_ratings[i]) shadow_ratings[i] = '0;
    foreach (shadow_weights[i]) shadow_weights[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    write_register(REG_LEARN_RATE, 16'hFFFF);
    write_register(REG_DECAY, 16'h0000);
    test_random(125);
    send_idle_pct = 57;
    write_register(REG_LEARN_RATE, 16'h0000);
    write_register(REG_DECAY, 16'hFFFF);
    test_random(125);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    write_register(REG_LEARN_RATE, 16'd852);
    write_register(REG_DECAY, 16'd66);
    test_random(125);
    send_idle_pct = 18;
    recv_stall_pct = 18;
    write_register(REG_LEARN_RATE, 16'd8000);
    write_register(REG_DECAY, 16'd3000);
    test_random(125);
    wait_drained();

    if (!failed) begin
      $display("item_similarity_rating_learner_top_tb: PASS");
    end else begin
      $display("item_similarity_rating_learner_top_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/isrl_pkg.sv
design/isrl_div.sv
design/item_similarity_rating_learner_top.sv
tb/sv/item_similarity_rating_learner_top_tb.sv
